### rtl/bmmf_pkg.sv
// Shared types and constants for the binary mask morphology filter.
package bmmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CFG_DW = 11;
    localparam int CFG_AW = 2;

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_FILTER_MODE  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_RADIUS       = 2'd3;

    localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 11'd1024;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_DILATE = 2'd1;
    localparam logic [1:0] MODE_ERODE  = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    typedef enum logic [1:0] {
        SCAN_DILATE_IN,
        SCAN_ERODE_IN,
        SCAN_ERODE_DIL
    } scan_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIL_SCAN,
        ST_DIL_DRAIN,
        ST_DIL_WR,
        ST_OUT_SCAN,
        ST_OUT_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       scan_start;
        logic       scan_on_j;
        scan_kind_t scan_kind;
        logic       scan_step;
        logic       dil_write;
        logic       out_load;
        logic       frame_clear;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       dil_needed;
        logic       out_due;
        logic       out_in_frame;
        logic       out_last;
        logic       scan_last;
        logic       out_free;
    } status_t;

endpackage

### rtl/bmmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmmf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/bmmf_ctrl.sv
// Sequencer for the mask filter: accept, window scans, store writes, result.
module bmmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bmmf_pkg::status_t status,
    output bmmf_pkg::cmd_t    cmd
);
    import bmmf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        logic out_decide;
        out_decide = 1'b0;
        cmd        = '0;
        cmd.scan_kind = SCAN_DILATE_IN;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.dil_needed)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_on_j  = 1'b1;
                    cmd.scan_kind  = SCAN_DILATE_IN;
                    state_next     = ST_DIL_SCAN;
                end
                else
                begin
                    out_decide = 1'b1;
                end
            end
            ST_DIL_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DIL_DRAIN;
                end
            end
            ST_DIL_DRAIN:
            begin
                state_next = ST_DIL_WR;
            end
            ST_DIL_WR:
            begin
                cmd.dil_write = 1'b1;
                out_decide    = 1'b1;
            end
            ST_OUT_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_OUT_DRAIN;
                end
            end
            ST_OUT_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.frame_clear = status.out_last;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_decide)
        begin
            if (!status.out_due)
            begin
                state_next = ST_IDLE;
            end
            else if (!status.out_in_frame)
            begin
                cmd.frame_clear = 1'b1;
                state_next      = ST_IDLE;
            end
            else if (status.mode == MODE_PASS)
            begin
                state_next = ST_EMIT;
            end
            else
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_on_j  = 1'b0;
                case (status.mode)
                    MODE_ERODE: cmd.scan_kind = SCAN_ERODE_IN;
                    MODE_CLOSE: cmd.scan_kind = SCAN_ERODE_DIL;
                    default:    cmd.scan_kind = SCAN_DILATE_IN;
                endcase
                state_next = ST_OUT_SCAN;
            end
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> state_reg == ST_IDLE)
        else $error("beat accepted outside idle");
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT_SCAN && status.scan_last) |=> state_reg == ST_OUT_DRAIN)
        else $error("scan did not drain");
    a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded into busy output");

endmodule

### rtl/bmmf_datapath.sv
// Datapath: config, frame counters, pixel stores, window scan, output register.
module bmmf_datapath #(
    parameter int MAX_WIDTH  = bmmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = bmmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bmmf_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [bmmf_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          in_func,
    input  logic                          in_mask,
    input  bmmf_pkg::cmd_t                cmd,
    output bmmf_pkg::status_t             status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_mask,
    output logic                          out_last
);
    import bmmf_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int SW = ((XW > YW) ? XW : YW) + 2;
    localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1);
    localparam int EW = PW + 2;
    localparam int STORE_DEPTH = 1 << $clog2(2 * MAX_RADIUS * (MAX_WIDTH + 1) + 1);
    localparam int AW = $clog2(STORE_DEPTH);

    logic [CFG_DW-1:0] w_cfg_reg;
    logic [CFG_DW-1:0] h_cfg_reg;
    logic [1:0]        mode_cfg_reg;
    logic [3:0]        rad_cfg_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] r_eff;
    logic [1:0]    mode_eff;
    logic [PW-1:0] total;
    logic [PW-1:0] d1;
    logic [PW-1:0] delay;

    logic [PW-1:0] n_reg;
    logic [PW-1:0] ncur_reg;
    logic          px_reg;
    logic [PW-1:0] jpos_reg;
    logic [XW-1:0] jx_reg;
    logic [YW-1:0] jy_reg;
    logic [PW-1:0] kpos_reg;
    logic [XW-1:0] kx_reg;
    logic [YW-1:0] ky_reg;

    scan_kind_t          kind_reg;
    logic [PW-1:0]       cpos_reg;
    logic [XW-1:0]       cx_reg;
    logic [YW-1:0]       cy_reg;
    logic signed [SW-1:0] dy_reg;
    logic signed [SW-1:0] dx_reg;
    logic                acc_reg;
    logic                vq_reg;
    logic                in_win_q_reg;

    logic signed [SW-1:0] r_s;
    logic signed [SW-1:0] ry;
    logic signed [SW-1:0] rx;
    logic                 in_win;
    logic signed [EW-1:0] dy_w;
    logic signed [EW-1:0] dx_w;
    logic signed [EW-1:0] w_w;
    logic signed [EW-1:0] prod;
    logic signed [EW-1:0] addr_full;
    logic [AW-1:0]        rd_addr;
    logic                 in_rdata;
    logic                 dil_rdata;
    logic                 rdata;
    logic                 erode;
    logic                 px;

    logic out_valid_reg;
    logic out_mask_reg;
    logic out_last_reg;

    // effective configuration
    always_comb
    begin
        if (w_cfg_reg == '0)
            w_eff = WW'(1);
        else if (32'(w_cfg_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(w_cfg_reg);
        if (h_cfg_reg == '0)
            h_eff = HW'(1);
        else if (32'(h_cfg_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(h_cfg_reg);
        if (32'(rad_cfg_reg) > MAX_RADIUS)
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(rad_cfg_reg);
        mode_eff = (r_eff == '0) ? MODE_PASS : mode_cfg_reg;
        total    = PW'(w_eff) * PW'(h_eff);
        d1       = PW'(r_eff) * (PW'(w_eff) + PW'(1));
        case (mode_eff)
            MODE_PASS:  delay = '0;
            MODE_CLOSE: delay = d1 << 1;
            default:    delay = d1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_cfg_reg    <= RST_FRAME_WIDTH;
            h_cfg_reg    <= RST_FRAME_HEIGHT;
            mode_cfg_reg <= MODE_PASS;
            rad_cfg_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  w_cfg_reg    <= cfg_data;
                REG_FRAME_HEIGHT: h_cfg_reg    <= cfg_data;
                REG_FILTER_MODE:  mode_cfg_reg <= cfg_data[1:0];
                REG_RADIUS:       rad_cfg_reg  <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            jpos_reg <= '0;
            jx_reg   <= '0;
            jy_reg   <= '0;
            kpos_reg <= '0;
            kx_reg   <= '0;
            ky_reg   <= '0;
        end
        else if (cfg_wr_en || cmd.frame_clear)
        begin
            n_reg    <= '0;
            jpos_reg <= '0;
            jx_reg   <= '0;
            jy_reg   <= '0;
            kpos_reg <= '0;
            kx_reg   <= '0;
            ky_reg   <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                n_reg <= n_reg + PW'(1);
            end
            if (cmd.dil_write)
            begin
                jpos_reg <= jpos_reg + PW'(1);
                if (WW'(jx_reg) == w_eff - WW'(1))
                begin
                    jx_reg <= '0;
                    jy_reg <= jy_reg + YW'(1);
                end
                else
                begin
                    jx_reg <= jx_reg + XW'(1);
                end
            end
            if (cmd.out_load)
            begin
                kpos_reg <= kpos_reg + PW'(1);
                if (WW'(kx_reg) == w_eff - WW'(1))
                begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + YW'(1);
                end
                else
                begin
                    kx_reg <= kx_reg + XW'(1);
                end
            end
        end
    end

    assign px = in_func ? 1'b0 : in_mask;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ncur_reg <= n_reg;
            px_reg   <= px;
        end
    end

    // window scan
    assign erode = (kind_reg != SCAN_DILATE_IN);
    assign r_s   = $signed(SW'(r_eff));
    assign ry    = $signed(SW'(cy_reg)) + dy_reg;
    assign rx    = $signed(SW'(cx_reg)) + dx_reg;
    assign in_win = (ry >= 0) && (ry < $signed(SW'(h_eff)))
                 && (rx >= 0) && (rx < $signed(SW'(w_eff)));
    assign dy_w      = EW'(dy_reg);
    assign dx_w      = EW'(dx_reg);
    assign w_w       = $signed(EW'(w_eff));
    assign prod      = dy_w * w_w;
    assign addr_full = $signed(EW'(cpos_reg)) + prod + dx_w;
    assign rd_addr   = addr_full[AW-1:0];
    assign rdata     = (kind_reg == SCAN_ERODE_DIL) ? dil_rdata : in_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
        end
        else
        begin
            vq_reg <= cmd.scan_step;
        end
    end

    always_ff @(posedge clk)
    begin
        in_win_q_reg <= in_win;
        if (cmd.scan_start)
        begin
            kind_reg <= cmd.scan_kind;
            cpos_reg <= cmd.scan_on_j ? jpos_reg : kpos_reg;
            cx_reg   <= cmd.scan_on_j ? jx_reg : kx_reg;
            cy_reg   <= cmd.scan_on_j ? jy_reg : ky_reg;
            dy_reg   <= -r_s;
            dx_reg   <= -r_s;
            acc_reg  <= (cmd.scan_kind != SCAN_DILATE_IN);
        end
        else
        begin
            if (cmd.scan_step)
            begin
                if (dx_reg == r_s)
                begin
                    dx_reg <= -r_s;
                    dy_reg <= dy_reg + SW'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + SW'(1);
                end
            end
            if (vq_reg)
            begin
                if (erode)
                    acc_reg <= acc_reg & in_win_q_reg & rdata;
                else
                    acc_reg <= acc_reg | (in_win_q_reg & rdata);
            end
        end
    end

    bmmf_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_in_store (
        .clk     (clk),
        .wr_en   (cmd.accept && (n_reg < total)),
        .wr_addr (n_reg[AW-1:0]),
        .wr_data (px),
        .rd_addr (rd_addr),
        .rd_data (in_rdata)
    );

    bmmf_ram #(
        .WIDTH (1),
        .DEPTH (STORE_DEPTH)
    ) u_dil_store (
        .clk     (clk),
        .wr_en   (cmd.dil_write),
        .wr_addr (jpos_reg[AW-1:0]),
        .wr_data (acc_reg),
        .rd_addr (rd_addr),
        .rd_data (dil_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mask_reg <= (mode_eff == MODE_PASS) ? px_reg : acc_reg;
            out_last_reg <= status.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_mask  = out_mask_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        status.mode         = mode_eff;
        status.dil_needed   = (mode_eff == MODE_CLOSE) && (ncur_reg >= d1)
                            && (jpos_reg < total);
        status.out_due      = (ncur_reg >= delay);
        status.out_in_frame = (kpos_reg < total);
        status.out_last     = (kpos_reg == total - PW'(1));
        status.scan_last    = (dy_reg == r_s) && (dx_reg == r_s);
        status.out_free     = !out_valid_reg || out_ready;
    end

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !cmd.scan_start)
        else $error("scan step and start together");
    a_dil_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dil_write |-> jpos_reg < total)
        else $error("dilated write outside frame");
    a_out_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> kpos_reg < total)
        else $error("result outside frame");
    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !vq_reg)
        else $error("beat accepted during scan");

endmodule

### rtl/binary_mask_morphology_filter_unit.sv
// Binary mask morphology filter: top level joining sequencer and datapath.
// Each input beat is accepted only while idle and is handled fully before the next:
// in close mode a dilated pixel may first be made by a serial window scan, then a
// result, if one is due, comes from a serial scan over the stores (no scan in
// pass-through mode) and is held in the output register while tready is low.
// Reset: async, active low; 1024x1024, pass-through, radius 0, counters cleared.
module binary_mask_morphology_filter_unit #(
    parameter int MAX_WIDTH  = bmmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = bmmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bmmf_pkg::CFG_AW-1:0] cfg_index,
    input  logic [bmmf_pkg::CFG_DW-1:0] cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [0] mask_in
    input  logic                        s_axis_tuser,  // [0] func
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,  // [0] mask_out
    output logic                        m_axis_tlast
);
    import bmmf_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    out_mask;

    bmmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmmf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_func   (s_axis_tuser),
        .in_mask   (s_axis_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_mask  (out_mask),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, out_mask};

endmodule
